// ===== design/yts_pkg.sv =====
// ----------------------------------------------------------------------------
// yts_pkg
// Shared types, widths, register codes and reset values of the yaw to turn
// speed latch.
// ----------------------------------------------------------------------------
`default_nettype none

package yts_pkg;

	localparam int CURVE_ENTRIES_DEF = 256;

	localparam int ANGLE_W = 15;
	localparam int SPEED_W = 16;
	localparam int YAW_W   = 16;
	localparam int OUT_W   = 17;
	localparam int TIDX_W  = 8;
	localparam int TVAL_W  = 16;
	localparam int CFGI_W  = 3;
	localparam int CFGD_W  = 16;
	localparam int PROD_W  = 34;

	localparam logic [ANGLE_W-1:0] MAG_MAX    = 15'h7fff;
	localparam logic [OUT_W-1:0]   CURVE_ONE  = 17'h10000;

	localparam logic [ANGLE_W-1:0] START_RST  = 15'd1280;
	localparam logic [ANGLE_W-1:0] STOP_RST   = 15'd640;
	localparam logic [ANGLE_W-1:0] MAXANG_RST = 15'd5760;
	localparam logic [ANGLE_W-1:0] MARGIN_RST = 15'd256;
	localparam logic [SPEED_W-1:0] MINSPD_RST = 16'd480;
	localparam logic [SPEED_W-1:0] MAXSPD_RST = 16'd2880;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TURN = 2'd1,
		PH_SUPP = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	typedef enum logic [CFGI_W-1:0] {
		CFG_START     = 3'd0,
		CFG_STOP      = 3'd1,
		CFG_MAX_ANGLE = 3'd2,
		CFG_MARGIN    = 3'd3,
		CFG_MIN_SPEED = 3'd4,
		CFG_MAX_SPEED = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_PREP,
		ST_DIV,
		ST_READ,
		ST_MUL,
		ST_SUM,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic prep;
		logic div_step;
		logic rd;
		logic mul;
		logic sum;
		logic emit;
	} yts_cmd_t;

	typedef struct packed {
		logic is_load;
		logic need_speed;
		logic need_div;
		logic out_busy;
	} yts_stat_t;

endpackage

`default_nettype wire

// ===== design/yts_if.sv =====
// ----------------------------------------------------------------------------
// yts_if
// Channel interfaces: sample input, result output and register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface yts_in_if import yts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic signed [YAW_W-1:0]  yaw;
	logic [TIDX_W-1:0]        table_index;
	logic [TVAL_W-1:0]        table_value;

	modport source (output valid, command, yaw, table_index, table_value, input ready);
	modport sink (input valid, command, yaw, table_index, table_value, output ready);
endinterface

interface yts_out_if import yts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  turn_speed;
	logic [1:0]               phase;

	modport source (output valid, turn_speed, phase, input ready);
	modport sink (input valid, turn_speed, phase, output ready);
endinterface

interface yts_cfg_if import yts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFGI_W-1:0]        index;
	logic [CFGD_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/yaw_to_turn_speed_latch.sv =====
// ----------------------------------------------------------------------------
// yaw_to_turn_speed_latch
// Yaw sample to signed turn speed with start/stop hysteresis and pullback
// suppression; curve table loaded through the sample channel.
// A load writes its table entry in the step state and returns to idle. A zero-speed
// sample goes from step to emit; a turning sample goes through prepare, the divide
// steps when needed, read, multiply, sum and emit. Only one item is in flight at a
// time; emit waits while the output beat is pending. One-bit-per-cycle restoring divider.
// Reset clears phase state and loads register defaults; the curve table is
// not cleared and must be loaded before turning samples arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module yaw_to_turn_speed_latch import yts_pkg::*; #(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	yts_in_if.sink     sample,
	yts_out_if.source  result,
	yts_cfg_if.sink    cfg
);

	yts_cmd_t  cmd;
	yts_stat_t stat;

	assign cfg.ready = 1'b1;

	yts_ctrl #(
		.CURVE_ENTRIES (CURVE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	yts_datapath #(
		.CURVE_ENTRIES (CURVE_ENTRIES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_command     (sample.command),
		.in_yaw         (sample.yaw),
		.in_table_index (sample.table_index),
		.in_table_value (sample.table_value),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_turn_speed (result.turn_speed),
		.out_phase      (result.phase)
	);

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !stat.out_busy)
		else $error("result beat overwritten while pending");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.phase != PH_TURN) |-> (result.turn_speed == '0))
		else $error("nonzero speed outside turning phase");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second item taken while one is in flight");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ===== design/yts_ctrl.sv =====
// ----------------------------------------------------------------------------
// yts_ctrl
// Sequencer: steps one item through phase update or table write, divide, table read,
// multiply, sum and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module yts_ctrl import yts_pkg::*; #(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire yts_stat_t stat,
	output yts_cmd_t       cmd
);

	localparam int IW = $clog2(CURVE_ENTRIES);
	localparam int CW = $clog2(IW + 1);

	ctrl_state_t    state_q, state_n;
	logic [CW-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_PREP) begin
				cnt_q <= CW'(IW);
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_STEP;
			end
			ST_STEP: begin
				if (stat.is_load)         state_n = ST_IDLE;
				else if (stat.need_speed) state_n = ST_PREP;
				else                      state_n = ST_EMIT;
			end
			ST_PREP: begin
				state_n = stat.need_div ? ST_DIV : ST_READ;
			end
			ST_DIV: begin
				if (cnt_q == CW'(1)) state_n = ST_READ;
			end
			ST_READ: state_n = ST_MUL;
			ST_MUL:  state_n = ST_SUM;
			ST_SUM:  state_n = ST_EMIT;
			ST_EMIT: begin
				if (!stat.out_busy) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.step     = (state_q == ST_STEP);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.rd       = (state_q == ST_READ);
		cmd.mul      = (state_q == ST_MUL);
		cmd.sum      = (state_q == ST_SUM);
		cmd.emit     = (state_q == ST_EMIT) && !stat.out_busy;
	end

endmodule

`default_nettype wire

// ===== design/yts_datapath.sv =====
// ----------------------------------------------------------------------------
// yts_datapath
// Registers, phase update logic, curve table, restoring divider, speed
// multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module yts_datapath import yts_pkg::*; #(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire yts_cmd_t                 cmd,
	output yts_stat_t                     stat,
	input  wire logic                     in_command,
	input  wire logic signed [YAW_W-1:0]  in_yaw,
	input  wire logic [TIDX_W-1:0]        in_table_index,
	input  wire logic [TVAL_W-1:0]        in_table_value,
	input  wire logic                     cfg_we,
	input  wire logic [CFGI_W-1:0]        cfg_index,
	input  wire logic [CFGD_W-1:0]        cfg_data,
	input  wire logic                     out_ready,
	output logic                          out_valid,
	output logic signed [OUT_W-1:0]       out_turn_speed,
	output logic [1:0]                    out_phase
);

	localparam int IW = $clog2(CURVE_ENTRIES);
	localparam int NW = ANGLE_W + $clog2(CURVE_ENTRIES + 1);

	// configuration registers
	logic [ANGLE_W-1:0] start_q, stop_q, max_ang_q, margin_q;
	logic [SPEED_W-1:0] min_spd_q, max_spd_q;

	// captured item
	logic                     cmd_q;
	logic signed [YAW_W-1:0]  yaw_q;
	logic [TIDX_W-1:0]        tidx_q;
	logic [TVAL_W-1:0]        tval_q;

	// phase state
	phase_t             phase_q;
	dir_t               ldir_q, sdir_q;
	logic [ANGLE_W-1:0] lmag_q, peak_q, smag_q;

	// speed datapath
	logic                      full_q;
	logic [ANGLE_W-1:0]        rem_q, dvs_q;
	logic [IW-1:0]             quo_q;
	logic [TVAL_W-1:0]         rdata_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [OUT_W-1:0]   res_speed_q;
	phase_t                    res_phase_q;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   out_speed_q;
	logic [1:0]                out_phase_q;

	logic [TVAL_W-1:0] curve_mem [CURVE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= START_RST;
			stop_q    <= STOP_RST;
			max_ang_q <= MAXANG_RST;
			margin_q  <= MARGIN_RST;
			min_spd_q <= MINSPD_RST;
			max_spd_q <= MAXSPD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START:     start_q   <= cfg_data[ANGLE_W-1:0];
				CFG_STOP:      stop_q    <= cfg_data[ANGLE_W-1:0];
				CFG_MAX_ANGLE: max_ang_q <= cfg_data[ANGLE_W-1:0];
				CFG_MARGIN:    margin_q  <= cfg_data[ANGLE_W-1:0];
				CFG_MIN_SPEED: min_spd_q <= cfg_data;
				CFG_MAX_SPEED: max_spd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= in_command;
			yaw_q  <= in_yaw;
			tidx_q <= in_table_index;
			tval_q <= in_table_value;
		end
	end

	// magnitude and side of the sample, yaw zero counts as positive
	logic [YAW_W-1:0]   yaw_abs;
	logic [ANGLE_W-1:0] mag;
	dir_t               dir;

	assign yaw_abs = yaw_q[YAW_W-1] ? YAW_W'(-yaw_q) : YAW_W'(yaw_q);
	assign mag     = yaw_abs[YAW_W-1] ? MAG_MAX : yaw_abs[ANGLE_W-1:0];
	assign dir     = yaw_q[YAW_W-1] ? DIR_NEG : DIR_POS;

	logic signed [ANGLE_W:0] margin_s, gap, pull;
	logic                    rearm, fin;
	phase_t                  ph_n;
	dir_t                    ld_n, sd_n;
	logic [ANGLE_W-1:0]      lm_n, pk_n, sm_n;

	assign margin_s = $signed({1'b0, margin_q});
	assign gap      = $signed({1'b0, mag}) - $signed({1'b0, smag_q});
	assign rearm    = (dir != sdir_q) || (gap >= margin_s);

	always_comb begin
		ph_n = phase_q;
		ld_n = ldir_q;
		lm_n = lmag_q;
		pk_n = peak_q;
		sd_n = sdir_q;
		sm_n = smag_q;
		fin  = 1'b0;
		pull = '0;
		if (ph_n == PH_SUPP) begin
			if (mag <= start_q) begin
				ph_n = PH_IDLE; ld_n = DIR_NONE; lm_n = '0; pk_n = '0;
				sd_n = DIR_NONE; sm_n = '0;
				fin  = 1'b1;
			end else if (rearm) begin
				ld_n = dir; lm_n = mag; pk_n = mag;
				sd_n = DIR_NONE; sm_n = '0;
				ph_n = PH_TURN;
			end else begin
				fin = 1'b1;
			end
		end
		if (!fin) begin
			if (ph_n == PH_TURN) begin
				if (mag <= stop_q) begin
					ph_n = PH_IDLE; ld_n = DIR_NONE; lm_n = '0; pk_n = '0;
					sd_n = DIR_NONE; sm_n = '0;
					fin  = 1'b1;
				end
			end else if (mag > start_q) begin
				ld_n = dir; lm_n = mag; pk_n = mag;
				ph_n = PH_TURN;
			end
		end
		if (!fin) begin
			if (ph_n != PH_TURN) begin
				fin = 1'b1;
			end else if ((dir == DIR_NEG) == (ld_n == DIR_NEG)) begin
				// same side: pullback from the peak suppresses
				pull = $signed({1'b0, pk_n}) - $signed({1'b0, mag});
				if (pull >= margin_s) begin
					sd_n = ld_n; sm_n = mag;
					ld_n = DIR_NONE; lm_n = '0; pk_n = '0;
					ph_n = PH_SUPP;
					fin  = 1'b1;
				end else begin
					lm_n = mag;
					if (mag > pk_n) pk_n = mag;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ldir_q  <= DIR_NONE;
			lmag_q  <= '0;
			peak_q  <= '0;
			sdir_q  <= DIR_NONE;
			smag_q  <= '0;
		end else if (cmd.step && !cmd_q) begin
			phase_q <= ph_n;
			ldir_q  <= ld_n;
			lmag_q  <= lm_n;
			peak_q  <= pk_n;
			sdir_q  <= sd_n;
			smag_q  <= sm_n;
		end
	end

	// normalization: n = floor(entries * (latched - start) / (max - start))
	logic              at_zero, at_full, need_div;
	logic [NW-1:0]     numer;
	logic [ANGLE_W:0]  trial;

	assign at_zero  = (lmag_q <= start_q);
	assign at_full  = (lmag_q >= max_ang_q);
	assign need_div = !at_zero && !at_full;
	assign numer    = NW'(ANGLE_W'(lmag_q - start_q)) * NW'(CURVE_ENTRIES);
	assign trial    = {rem_q, quo_q[IW-1]};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			full_q <= !at_zero && at_full;
			dvs_q  <= ANGLE_W'(max_ang_q - start_q);
			if (need_div) begin
				rem_q <= ANGLE_W'(numer >> IW);
				quo_q <= numer[IW-1:0];
			end else begin
				rem_q <= '0;
				quo_q <= '0;
			end
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= ANGLE_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[IW-2:0], 1'b1};
			end else begin
				rem_q <= trial[ANGLE_W-1:0];
				quo_q <= {quo_q[IW-2:0], 1'b0};
			end
		end
	end

	logic tbl_we;
	assign tbl_we = cmd.step && cmd_q && ({24'd0, tidx_q} < 32'(CURVE_ENTRIES));

	always_ff @(posedge clk) begin
		if (tbl_we) curve_mem[IW'(tidx_q)] <= tval_q;
		if (cmd.rd) rdata_q <= curve_mem[quo_q];
	end

	logic [OUT_W-1:0]          curve;
	logic signed [OUT_W-1:0]   spd_diff;
	logic signed [OUT_W:0]     spd_sum;
	logic signed [OUT_W-1:0]   spd_pos;

	assign curve    = full_q ? CURVE_ONE : {1'b0, rdata_q};
	assign spd_diff = $signed({1'b0, max_spd_q}) - $signed({1'b0, min_spd_q});
	// top bits of the product are the floor of product / 65536
	assign spd_sum  = $signed({2'b00, min_spd_q}) + $signed(prod_q[PROD_W-1:16]);
	assign spd_pos  = OUT_W'(spd_sum);

	// curve is unsigned, full scale sets its top bit
	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= spd_diff * $signed({1'b0, curve});
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			res_phase_q <= ph_n;
			res_speed_q <= '0;
		end else if (cmd.sum) begin
			res_speed_q <= (ldir_q == DIR_NEG) ? -spd_pos : spd_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_speed_q <= res_speed_q;
			out_phase_q <= res_phase_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_turn_speed = out_speed_q;
	assign out_phase      = out_phase_q;

	always_comb begin
		stat            = '0;
		stat.is_load    = cmd_q;
		stat.need_speed = !fin;
		stat.need_div   = need_div;
		stat.out_busy   = out_valid_q && !out_ready;
	end

endmodule

`default_nettype wire
